[hdl/grp_pkg.sv]
// Shared types and constants of the guillotine rectangle packer.
// Used by the controller, the datapath, the top level and the checker.
package grp_pkg;

    localparam int INITIAL_SIZE = 1024;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        RES_PLACED    = 2'd0,
        RES_NO_FIT    = 2'd1,
        RES_LIST_FULL = 2'd2
    } res_code_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_START,
        WR_CUT_SEL,
        WR_APPEND,
        WR_SHIFT
    } wr_src_t;

    typedef enum logic [2:0] {
        CTL_INIT,
        CTL_IDLE,
        CTL_START,
        CTL_SCAN,
        CTL_DECIDE,
        CTL_APPEND,
        CTL_SHIFT,
        CTL_DONE
    } ctl_state_t;

    typedef struct packed {
        logic      load_in;
        logic      scan_clear;
        logic      scan;
        logic      shift;
        logic      shift_init;
        logic      start;
        logic      place;
        logic      res_load;
        res_code_t res_code;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      out_load;
        wr_src_t   wr_src;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic found;
        logic narrower;
        logic shorter;
        logic full;
        logic out_free;
    } sts_t;

endpackage

[hdl/grp_datapath.sv]
// Datapath of the rectangle packer: free box memory, scan pipeline, cut logic,
// extents, configuration registers and the result register.
// Depends on grp_pkg; driven by grp_ctrl.
module grp_datapath #(
    parameter int MAX_FREE   = 64,
    parameter int COORD_BITS = 13
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [grp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_wdata,
    input  logic [COORD_BITS-1:0]               s_item_width,
    input  logic [COORD_BITS-1:0]               s_item_height,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [1:0]                          m_status,
    output logic [COORD_BITS-1:0]               m_place_x,
    output logic [COORD_BITS-1:0]               m_place_y,
    output logic [COORD_BITS-1:0]               m_used_width,
    output logic [COORD_BITS-1:0]               m_used_height,
    input  grp_pkg::cmd_t                       cmd,
    output grp_pkg::sts_t                       sts
);
    localparam int CB = COORD_BITS;
    localparam int IW = $clog2(MAX_FREE);
    localparam int CW = $clog2(MAX_FREE + 1);
    localparam int BW = 4 * CB;
    localparam int AW = 2 * CB;

    logic [BW-1:0] box_mem [MAX_FREE];

    logic [CB-1:0] atlas_w_reg, atlas_h_reg;
    logic [CB-1:0] iw_reg, ih_reg;
    logic [CW-1:0] count_reg;
    logic [CB-1:0] ext_x_reg, ext_y_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic          v1_reg;
    logic [IW-1:0] idx1_reg;
    logic [BW-1:0] rd_data_reg;
    logic          v2_reg, fit2_reg;
    logic [AW-1:0] area2_reg;
    logic [BW-1:0] box2_reg;
    logic [IW-1:0] idx2_reg;
    logic          found_reg;
    logic [AW-1:0] best_area_reg;
    logic [BW-1:0] best_box_reg;
    logic [IW-1:0] sel_reg;
    logic [1:0]    res_code_reg;
    logic [CB-1:0] res_px_reg, res_py_reg;
    logic          m_valid_reg;
    logic [1:0]    m_status_reg;
    logic [CB-1:0] m_px_reg, m_py_reg, m_uw_reg, m_uh_reg;

    logic          rd_more, issue;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [BW-1:0] wr_data;
    logic [CB-1:0] bx, by, bw, bh;
    logic [CB-1:0] r_w, r_h;
    logic [CB-1:0] ex_next, ey_next;

    assign bx = best_box_reg[4*CB-1 -: CB];
    assign by = best_box_reg[3*CB-1 -: CB];
    assign bw = best_box_reg[2*CB-1 -: CB];
    assign bh = best_box_reg[CB-1:0];
    assign r_w = rd_data_reg[2*CB-1 -: CB];
    assign r_h = rd_data_reg[CB-1:0];

    assign rd_more = rd_ptr_reg < count_reg;
    assign issue   = (cmd.scan || cmd.shift) && rd_more;
    assign ex_next = bx + iw_reg;
    assign ey_next = by + ih_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (cmd.wr_src)
            grp_pkg::WR_NONE: begin
                wr_en = 1'b0;
            end
            grp_pkg::WR_INIT: begin
                wr_en   = 1'b1;
                wr_data = {{AW{1'b0}}, CB'(grp_pkg::INITIAL_SIZE),
                           CB'(grp_pkg::INITIAL_SIZE)};
            end
            grp_pkg::WR_START: begin
                wr_en   = 1'b1;
                wr_data = {{AW{1'b0}}, atlas_w_reg, atlas_h_reg};
            end
            grp_pkg::WR_CUT_SEL: begin
                wr_en   = 1'b1;
                wr_addr = sel_reg;
                if (sts.narrower) begin
                    wr_data = {ex_next, by, bw - iw_reg, bh};
                end else begin
                    wr_data = {bx, ey_next, bw, bh - ih_reg};
                end
            end
            grp_pkg::WR_APPEND: begin
                wr_en   = 1'b1;
                wr_addr = count_reg[IW-1:0];
                wr_data = {bx, ey_next, iw_reg, bh - ih_reg};
            end
            grp_pkg::WR_SHIFT: begin
                wr_en   = v1_reg;
                wr_addr = idx1_reg - IW'(1);
                wr_data = rd_data_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            box_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= box_mem[rd_ptr_reg[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_w_reg <= CB'(grp_pkg::INITIAL_SIZE);
            atlas_h_reg <= CB'(grp_pkg::INITIAL_SIZE);
        end else if (cfg_wr_en) begin
            if (cfg_index == grp_pkg::REG_ATLAS_WIDTH) begin
                atlas_w_reg <= cfg_wdata;
            end
            if (cfg_index == grp_pkg::REG_ATLAS_HEIGHT) begin
                atlas_h_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            iw_reg <= s_item_width;
            ih_reg <= s_item_height;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end else begin
            if (cmd.scan_clear) begin
                rd_ptr_reg <= '0;
            end else if (cmd.shift_init) begin
                rd_ptr_reg <= CW'(sel_reg) + CW'(1);
            end else if (issue) begin
                rd_ptr_reg <= rd_ptr_reg + CW'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg && cmd.scan;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg  <= rd_ptr_reg[IW-1:0];
        idx2_reg  <= idx1_reg;
        box2_reg  <= rd_data_reg;
        fit2_reg  <= (r_w >= iw_reg) && (r_h >= ih_reg);
        area2_reg <= AW'(r_w) * AW'(r_h);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.scan_clear) begin
            found_reg <= 1'b0;
        end else if (v2_reg && fit2_reg && (!found_reg || area2_reg > best_area_reg)) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && fit2_reg && (!found_reg || area2_reg > best_area_reg)) begin
            best_area_reg <= area2_reg;
            best_box_reg  <= box2_reg;
            sel_reg       <= idx2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(1);
            ext_x_reg <= '0;
            ext_y_reg <= '0;
        end else begin
            if (cmd.start) begin
                count_reg <= CW'(1);
                ext_x_reg <= '0;
                ext_y_reg <= '0;
            end else begin
                if (cmd.cnt_inc) begin
                    count_reg <= count_reg + CW'(1);
                end else if (cmd.cnt_dec) begin
                    count_reg <= count_reg - CW'(1);
                end
                if (cmd.place && ex_next > ext_x_reg) begin
                    ext_x_reg <= ex_next;
                end
                if (cmd.place && ey_next > ext_y_reg) begin
                    ext_y_reg <= ey_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_code_reg <= cmd.res_code;
            res_px_reg   <= cmd.place ? bx : '0;
            res_py_reg   <= cmd.place ? by : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_code_reg;
            m_px_reg     <= res_px_reg;
            m_py_reg     <= res_py_reg;
            m_uw_reg     <= ext_x_reg;
            m_uh_reg     <= ext_y_reg;
        end
    end

    always_comb begin
        sts.scan_done  = !rd_more && !v1_reg && !v2_reg;
        sts.shift_done = !rd_more && !v1_reg;
        sts.found      = found_reg;
        sts.narrower   = iw_reg < bw;
        sts.shorter    = ih_reg < bh;
        sts.full       = count_reg >= CW'(MAX_FREE);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_place_x     = m_px_reg;
    assign m_place_y     = m_py_reg;
    assign m_used_width  = m_uw_reg;
    assign m_used_height = m_uh_reg;

endmodule

[hdl/grp_ctrl.sv]
// Controller of the rectangle packer: sequences scan, cut, shift and result.
// Depends on grp_pkg; drives grp_datapath through cmd_t and reads sts_t.
module grp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_func,
    output logic            s_ready,
    output grp_pkg::cmd_t   cmd,
    input  grp_pkg::sts_t   sts
);
    grp_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= grp_pkg::CTL_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            grp_pkg::CTL_INIT: begin
                state_next = grp_pkg::CTL_IDLE;
            end
            grp_pkg::CTL_IDLE: begin
                if (s_valid) begin
                    state_next = s_func ? grp_pkg::CTL_START : grp_pkg::CTL_SCAN;
                end
            end
            grp_pkg::CTL_START: begin
                state_next = grp_pkg::CTL_DONE;
            end
            grp_pkg::CTL_SCAN: begin
                if (sts.scan_done) begin
                    state_next = grp_pkg::CTL_DECIDE;
                end
            end
            grp_pkg::CTL_DECIDE: begin
                priority if (!sts.found) begin
                    state_next = grp_pkg::CTL_DONE;
                end else if (sts.narrower && sts.shorter) begin
                    state_next = sts.full ? grp_pkg::CTL_DONE : grp_pkg::CTL_APPEND;
                end else if (sts.narrower || sts.shorter) begin
                    state_next = grp_pkg::CTL_DONE;
                end else begin
                    state_next = grp_pkg::CTL_SHIFT;
                end
            end
            grp_pkg::CTL_APPEND: begin
                state_next = grp_pkg::CTL_DONE;
            end
            grp_pkg::CTL_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = grp_pkg::CTL_DONE;
                end
            end
            grp_pkg::CTL_DONE: begin
                if (sts.out_free) begin
                    state_next = grp_pkg::CTL_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.res_code = grp_pkg::RES_PLACED;
        cmd.wr_src   = grp_pkg::WR_NONE;
        s_ready      = 1'b0;
        unique case (state_reg)
            grp_pkg::CTL_INIT: begin
                cmd.wr_src = grp_pkg::WR_INIT;
            end
            grp_pkg::CTL_IDLE: begin
                s_ready        = 1'b1;
                cmd.load_in    = s_valid;
                cmd.scan_clear = s_valid;
            end
            grp_pkg::CTL_START: begin
                cmd.wr_src   = grp_pkg::WR_START;
                cmd.start    = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_code = grp_pkg::RES_PLACED;
            end
            grp_pkg::CTL_SCAN: begin
                cmd.scan = 1'b1;
            end
            grp_pkg::CTL_DECIDE: begin
                cmd.res_load = 1'b1;
                priority if (!sts.found) begin
                    cmd.res_code = grp_pkg::RES_NO_FIT;
                end else if (sts.narrower && sts.shorter && sts.full) begin
                    cmd.res_code = grp_pkg::RES_LIST_FULL;
                end else if (sts.narrower || sts.shorter) begin
                    cmd.res_code = grp_pkg::RES_PLACED;
                    cmd.place    = 1'b1;
                    cmd.wr_src   = grp_pkg::WR_CUT_SEL;
                end else begin
                    cmd.res_code   = grp_pkg::RES_PLACED;
                    cmd.place      = 1'b1;
                    cmd.shift_init = 1'b1;
                end
            end
            grp_pkg::CTL_APPEND: begin
                cmd.wr_src  = grp_pkg::WR_APPEND;
                cmd.cnt_inc = 1'b1;
            end
            grp_pkg::CTL_SHIFT: begin
                cmd.shift   = 1'b1;
                cmd.wr_src  = grp_pkg::WR_SHIFT;
                cmd.cnt_dec = sts.shift_done;
            end
            grp_pkg::CTL_DONE: begin
                cmd.out_load = sts.out_free;
            end
        endcase
    end

endmodule

[hdl/guillotine_rect_packer.sv]
// Guillotine rectangle packer with largest-area fit over a free box list of
// MAX_FREE entries. One transaction at a time. A place request scans every
// free box through the single read port of the free box memory and its
// two-stage pipeline. A cut that leaves two pieces appends a box; an exact fit
// shifts the boxes after the chosen one down to close the gap. After reset the
// whole-atlas box is written before the first transaction is accepted. Results
// wait in an output register, and a stalled result holds the next result, and
// with it the block, until it is taken. Atlas size writes take effect at the
// next start.
module guillotine_rect_packer #(
    parameter int MAX_FREE   = 64,
    parameter int COORD_BITS = 13
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [grp_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]            cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [COORD_BITS-1:0]            s_item_width,
    input  logic [COORD_BITS-1:0]            s_item_height,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [COORD_BITS-1:0]            m_place_x,
    output logic [COORD_BITS-1:0]            m_place_y,
    output logic [COORD_BITS-1:0]            m_used_width,
    output logic [COORD_BITS-1:0]            m_used_height
);
    grp_pkg::cmd_t cmd;
    grp_pkg::sts_t sts;

    grp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    grp_datapath #(
        .MAX_FREE   (MAX_FREE),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_item_width  (s_item_width),
        .s_item_height (s_item_height),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_place_x     (m_place_x),
        .m_place_y     (m_place_y),
        .m_used_width  (m_used_width),
        .m_used_height (m_used_height),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

[hdl/grp_checker.sv]
// Port-level checks of the rectangle packer's result channel.
// Depends on grp_pkg; bound to guillotine_rect_packer.
module grp_checker #(
    parameter int COORD_BITS = 13
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_status,
    input logic [COORD_BITS-1:0] m_place_x,
    input logic [COORD_BITS-1:0] m_place_y,
    input logic [COORD_BITS-1:0] m_used_width,
    input logic [COORD_BITS-1:0] m_used_height
);
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_place_x)
            && $stable(m_place_y) && $stable(m_used_width) && $stable(m_used_height))
        else $error("stalled transaction changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != grp_pkg::RES_PLACED) |-> (m_place_x == '0)
            && (m_place_y == '0))
        else $error("failed placement reports coordinates");

endmodule

bind guillotine_rect_packer grp_checker #(.COORD_BITS(COORD_BITS)) u_grp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_place_x     (m_place_x),
    .m_place_y     (m_place_y),
    .m_used_width  (m_used_width),
    .m_used_height (m_used_height)
);
